// ----- hdl/lkv_pkg.sv -----
// Shared constants, payload words and control structs for the LRU key/value cache.
package lkv_pkg;

  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int CAP_W      = 5;

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int RANK_W = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_SET = 1'b1;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef struct packed {
    logic                         action;
    logic signed [KEY_BITS-1:0]   lookup_key;
    logic signed [VALUE_BITS-1:0] store_value;
  } in_word_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] read_value;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic look;
    logic upd;
  } cmd_t;

  typedef struct packed {
    logic is_get;
  } status_t;

endpackage

// ----- hdl/lru_key_value_cache.sv -----
// Top level of the fully associative LRU key/value cache.
//
//   port group   direction  handshake           word
//   in_          input      in_valid/in_ready   in_word_t {action, lookup_key, store_value}
//   out_         output     out_valid/out_ready out_word_t {found, read_value}
//   cfg_         input      cfg_wr_en           cfg_wr_data = capacity
//
// Each request passes through accept, parallel key compare over all entries,
// then rank update and entry writeback in one step. A get waits in the compare
// step while the previous result word is still unread.
// Reset clears the valid bits and fill count and sets capacity to 16 at once; no sweep.
// A set produces no result word.
module lru_key_value_cache
  import lkv_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_data,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data
);

  cmd_t    cmd;
  status_t stat;

  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lkv_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_data    (out_data)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a word while busy");

  a_get_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd && stat.is_get |=> out_valid)
    else $error("get finished without a result word");

  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.look, cmd.upd}))
    else $error("overlapping sequencer steps");

  a_look_leads_upd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.look |=> cmd.look || cmd.upd)
    else $error("compare step left without update");
`endif

endmodule

// ----- hdl/lkv_ctrl.sv -----
// Request sequencer: accept, compare, update, and the result word valid flag.
module lkv_ctrl
  import lkv_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t stat,
  output cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPD
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_busy;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_busy  = out_valid_r && !out_ready;

  assign cmd.load = (state_r == ST_IDLE) && in_valid;
  assign cmd.look = (state_r == ST_LOOK);
  assign cmd.upd  = (state_r == ST_UPD);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        // hold while the previous result word is still unread
        if (!(stat.is_get && out_busy)) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        state_nxt = ST_IDLE;
        if (stat.is_get) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- hdl/lkv_dp.sv -----
// Entry storage, parallel key compare, recency ranks and result register.
module lkv_dp
  import lkv_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data,
  input  in_word_t         in_data,
  input  cmd_t             cmd,
  output status_t          stat,
  output out_word_t        out_data
);

  in_word_t                    req_r;
  logic [CAP_W-1:0]            cap_r;
  logic [ENTRIES-1:0]          valid_r;
  logic [ENTRIES-1:0]          valid_nxt;
  logic [CNT_W-1:0]            fill_r;
  logic [CNT_W-1:0]            fill_nxt;
  logic [KEY_BITS-1:0]         key_r   [ENTRIES];
  logic [VALUE_BITS-1:0]       val_r   [ENTRIES];
  logic [RANK_W-1:0]           rank_r  [ENTRIES];
  logic [RANK_W-1:0]           rank_nxt[ENTRIES];
  logic                        hit_r;
  logic [IDX_W-1:0]            hit_idx_r;
  logic [IDX_W-1:0]            old_idx_r;
  logic                        evict_r;
  out_word_t                   out_r;

  logic                        hit_c;
  logic [IDX_W-1:0]            hit_idx_c;
  logic [IDX_W-1:0]            old_idx_c;
  logic                        evict_c;
  logic [CMP_W-1:0]            eff_cap;
  logic [RANK_W-1:0]           oldest_rank;
  logic [RANK_W-1:0]           hit_rank;
  logic [ENTRIES-1:0]          valid_kept;
  logic [IDX_W-1:0]            slot_c;

  assign stat.is_get = (req_r.action == ACT_GET);
  assign out_data    = out_r;

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(cap_r) > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = CMP_W'(cap_r);
    end
  end

  assign oldest_rank = RANK_W'(fill_r - CNT_W'(1));
  assign evict_c     = CMP_W'(fill_r) >= eff_cap;

  always_comb begin
    hit_c     = 1'b0;
    hit_idx_c = '0;
    old_idx_c = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && key_r[i] == req_r.lookup_key) begin
        hit_c     = 1'b1;
        hit_idx_c = IDX_W'(i);
      end
      if (valid_r[i] && rank_r[i] == oldest_rank) begin
        old_idx_c = IDX_W'(i);
      end
    end
  end

  assign hit_rank = rank_r[hit_idx_r];

  always_comb begin
    valid_kept = valid_r;
    if (evict_r) begin
      valid_kept[old_idx_r] = 1'b0;
    end
    slot_c = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_kept[i]) begin
        slot_c = IDX_W'(i);
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    fill_nxt  = fill_r;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    if (cmd.upd) begin
      if (hit_r) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_r[i] && rank_r[i] < hit_rank) begin
            rank_nxt[i] = rank_r[i] + RANK_W'(1);
          end
        end
        rank_nxt[hit_idx_r] = '0;
      end else if (req_r.action == ACT_SET) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_kept[i]) begin
            rank_nxt[i] = rank_r[i] + RANK_W'(1);
          end
        end
        rank_nxt[slot_c]  = '0;
        valid_nxt         = valid_kept;
        valid_nxt[slot_c] = 1'b1;
        if (!evict_r) begin
          fill_nxt = fill_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      valid_r <= '0;
      fill_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      valid_r <= valid_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (cmd.look) begin
      hit_r     <= hit_c;
      hit_idx_r <= hit_idx_c;
      old_idx_r <= old_idx_c;
      evict_r   <= evict_c;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      rank_r[i] <= rank_nxt[i];
    end
    if (cmd.upd) begin
      if (req_r.action == ACT_GET) begin
        out_r.found      <= hit_r;
        out_r.read_value <= hit_r ? 32'(val_r[hit_idx_r]) : '1;
      end else if (hit_r) begin
        val_r[hit_idx_r] <= req_r.store_value;
      end else begin
        key_r[slot_c] <= req_r.lookup_key;
        val_r[slot_c] <= req_r.store_value;
      end
    end
  end

endmodule
